FILE: rtl/stlf_pkg.sv
// ---------------------------------------------------------------------------
// stlf_pkg
// Shared types and codes for the start/type/length frame receiver.
// ---------------------------------------------------------------------------
package stlf_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 16;
  localparam int KIND_W  = 2;
  localparam int ODATA_W = 2 * BYTE_W + LEN_W;

  // Configuration register indexes
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd170;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 16'd63;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;

  // Input command codes
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] frame_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    logic [LEN_W-1:0]  frame_length;
  } res_t;

endpackage

FILE: rtl/stlf_core.sv
// ---------------------------------------------------------------------------
// stlf_core
// Frame parser: hunts for the start byte, captures type and length, and
// produces one result per payload byte, abort or rejected length.
// ---------------------------------------------------------------------------
module stlf_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  logic                          command,
  input  logic [stlf_pkg::BYTE_W-1:0]   rx_byte,
  input  stlf_pkg::cfg_t                cfg,
  output logic                          res_valid,
  output stlf_pkg::res_t                res
);
  import stlf_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] held_kind, held_kind_next;
  logic [LEN_W-1:0]  held_length, held_length_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [LEN_W-1:0]  len_full;
  logic              timeout;
  logic              fin;

  assign timeout  = (command == CMD_TIMEOUT);
  assign len_full = {rx_byte, held_length[BYTE_W-1:0]};
  assign fin      = (bytes_left <= LEN_W'(1));

  always_comb begin
    phase_next       = phase;
    held_kind_next   = held_kind;
    held_length_next = held_length;
    bytes_left_next  = bytes_left;
    res_valid        = 1'b0;
    res.kind         = KIND_PAYLOAD;
    res.frame_kind   = held_kind;
    res.payload_byte = '0;
    res.last         = 1'b0;
    res.frame_length = held_length;

    if (phase == PH_TYPE || phase == PH_LEN_LO || phase == PH_LEN_HI ||
        phase == PH_PAYLOAD) begin
      if (timeout) begin
        res_valid        = 1'b1;
        res.kind         = KIND_ABORT;
        held_length_next = '0;
        bytes_left_next  = '0;
        phase_next       = PH_HUNT;
      end else begin
        unique case (phase)
          PH_TYPE: begin
            held_kind_next = rx_byte;
            phase_next     = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            held_length_next = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
            phase_next       = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (len_full == '0 || len_full > cfg.max_length) begin
              res_valid        = 1'b1;
              res.kind         = KIND_REJECT;
              res.frame_length = len_full;
              held_length_next = '0;
              bytes_left_next  = '0;
              phase_next       = PH_HUNT;
            end else begin
              held_length_next = len_full;
              bytes_left_next  = len_full;
              phase_next       = PH_PAYLOAD;
            end
          end
          default: begin
            res_valid        = 1'b1;
            res.payload_byte = rx_byte;
            res.last         = fin;
            if (fin) begin
              bytes_left_next = '0;
              phase_next      = PH_HUNT;
            end else begin
              bytes_left_next = bytes_left - LEN_W'(1);
            end
          end
        endcase
      end
    end else begin
      // Hunting, or a code that means nothing: look for the start byte
      phase_next = PH_HUNT;
      if (!timeout && rx_byte == cfg.start_byte) begin
        held_kind_next   = '0;
        held_length_next = '0;
        bytes_left_next  = '0;
        phase_next       = PH_TYPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      held_kind   <= '0;
      held_length <= '0;
      bytes_left  <= '0;
    end else if (acc) begin
      phase       <= phase_next;
      held_kind   <= held_kind_next;
      held_length <= held_length_next;
      bytes_left  <= bytes_left_next;
    end
  end

`ifndef SYNTH
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (acc && res_valid && res.kind == KIND_PAYLOAD && res.last) |=> (phase == PH_HUNT))
    else $error("frame did not end after last payload byte");

  a_reject_from_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_REJECT) |-> (phase == PH_LEN_HI))
    else $error("length rejected outside the length phase");

  a_hunt_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> !res_valid)
    else $error("result produced while hunting");

  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != '0 && bytes_left <= held_length))
    else $error("payload count out of range");
`endif

endmodule

FILE: rtl/stlf_out_stage.sv
// ---------------------------------------------------------------------------
// stlf_out_stage
// Result register on the master side; frees the slave side whenever the
// register is empty or being drained.
// ---------------------------------------------------------------------------
module stlf_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           acc,
  input  logic                           res_valid,
  input  stlf_pkg::res_t                 res,
  output logic                           ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [stlf_pkg::ODATA_W-1:0]   m_tdata,  // frame_kind, payload_byte, frame_length
  output logic [stlf_pkg::KIND_W-1:0]    m_tuser,  // kind
  output logic                           m_tlast   // last
);
  import stlf_pkg::*;

  res_t held;

  assign ready   = !m_tvalid || m_tready;
  assign m_tdata = {held.frame_length, held.payload_byte, held.frame_kind};
  assign m_tuser = held.kind;
  assign m_tlast = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (acc) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload: load on every accepted transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      held <= res;
    end
  end

endmodule

FILE: rtl/start_type_length_frame_receiver.sv
// Output: a result is registered and appears on the master side in the cycle after its input transfer.
// Throughput: one transfer per cycle; the single result register stalls it while full.
// Reset (rst, synchronous): parser hunts for the start byte, held type and length clear,
// result register empties, start_byte returns to 170 and max_length to 63.
// ---------------------------------------------------------------------------
// start_type_length_frame_receiver
// Deframes start byte / type / 16-bit little-endian length / payload from a
// byte and timeout stream, streaming payload bytes as they arrive.
// ---------------------------------------------------------------------------
module start_type_length_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [stlf_pkg::BYTE_W-1:0]    s_tdata,  // rx_byte
  input  logic                           s_tuser,  // command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [stlf_pkg::ODATA_W-1:0]   m_tdata,  // frame_kind, payload_byte, frame_length
  output logic [stlf_pkg::KIND_W-1:0]    m_tuser,  // kind
  output logic                           m_tlast,  // last
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [stlf_pkg::LEN_W-1:0]     cfg_wdata
);
  import stlf_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic acc;

  assign acc = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_BYTE_RST;
      cfg.max_length <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_BYTE: cfg.start_byte <= cfg_wdata[BYTE_W-1:0];
        REG_MAX_LENGTH: cfg.max_length <= cfg_wdata;
        default:        cfg.max_length <= cfg.max_length;
      endcase
    end
  end

  stlf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .command   (s_tuser),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  stlf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .res_valid (res_valid),
    .res       (res),
    .ready     (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: dv/stlf_result_checker.sv
// ---------------------------------------------------------------------------
// stlf_result_checker
// Watches the byte/timeout input channel, the configuration port and the
// result channel of the frame receiver. Predicts each result from accepted
// input transfers and compares it field by field with what comes out.
// ---------------------------------------------------------------------------
module stlf_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [stlf_pkg::BYTE_W-1:0]  s_tdata,    // rx_byte
  input  logic                         s_tuser,    // command
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [stlf_pkg::ODATA_W-1:0] m_tdata,    // frame_kind, payload_byte, frame_length
  input  logic [stlf_pkg::KIND_W-1:0]  m_tuser,    // kind
  input  logic                         m_tlast,    // last
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [stlf_pkg::LEN_W-1:0]   cfg_wdata,
  output int                           fail_count,
  output int                           pending
);
  import stlf_pkg::*;

  typedef enum logic [2:0] {
    HUNT,
    WAIT_TYPE,
    WAIT_LEN_LO,
    WAIT_LEN_HI,
    IN_PAYLOAD
  } parse_phase_e;

  parse_phase_e      parse_phase;
  logic [BYTE_W-1:0] start_byte_q;
  logic [LEN_W-1:0]  max_len_q;
  logic [BYTE_W-1:0] held_kind;
  logic [LEN_W-1:0]  held_len;
  logic [LEN_W-1:0]  bytes_left;

  res_t expected_results[$];
  int   errors = 0;

  assign fail_count = errors;

  task automatic report(input string what, input logic [LEN_W-1:0] got,
                        input logic [LEN_W-1:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Advance the parser by one transfer; returns 1 when a result is due.
  function automatic bit deframe_step(input logic cmd, input logic [BYTE_W-1:0] b,
                                      output res_t r);
    bit fin;
    r = '0;
    if (parse_phase == HUNT) begin
      if (cmd == CMD_BYTE && b == start_byte_q) begin
        held_kind   = '0;
        held_len    = '0;
        bytes_left  = '0;
        parse_phase = WAIT_TYPE;
      end
      return 1'b0;
    end
    if (cmd == CMD_TIMEOUT) begin
      r.kind         = KIND_ABORT;
      r.frame_kind   = held_kind;
      r.frame_length = held_len;
      held_len       = '0;
      bytes_left     = '0;
      parse_phase    = HUNT;
      return 1'b1;
    end
    case (parse_phase)
      WAIT_TYPE: begin
        held_kind   = b;
        parse_phase = WAIT_LEN_LO;
        return 1'b0;
      end
      WAIT_LEN_LO: begin
        held_len    = {{(LEN_W-BYTE_W){1'b0}}, b};
        parse_phase = WAIT_LEN_HI;
        return 1'b0;
      end
      WAIT_LEN_HI: begin
        held_len = {b, held_len[BYTE_W-1:0]};
        if (held_len == '0 || held_len > max_len_q) begin
          r.kind         = KIND_REJECT;
          r.frame_kind   = held_kind;
          r.frame_length = held_len;
          held_len       = '0;
          bytes_left     = '0;
          parse_phase    = HUNT;
          return 1'b1;
        end
        bytes_left  = held_len;
        parse_phase = IN_PAYLOAD;
        return 1'b0;
      end
      default: begin
        fin            = (bytes_left <= 1);
        r.kind         = KIND_PAYLOAD;
        r.frame_kind   = held_kind;
        r.payload_byte = b;
        r.last         = fin;
        r.frame_length = held_len;
        if (fin) begin
          bytes_left  = '0;
          parse_phase = HUNT;
        end else begin
          bytes_left = bytes_left - 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    res_t pred;
    if (rst) begin
      parse_phase  = HUNT;
      start_byte_q = START_BYTE_RST;
      max_len_q    = MAX_LENGTH_RST;
      held_kind    = '0;
      held_len     = '0;
      bytes_left   = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_BYTE: start_byte_q = cfg_wdata[BYTE_W-1:0];
          REG_MAX_LENGTH: max_len_q    = cfg_wdata;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen.kind         = m_tuser;
        seen.frame_kind   = m_tdata[BYTE_W-1:0];
        seen.payload_byte = m_tdata[2*BYTE_W-1:BYTE_W];
        seen.last         = m_tlast;
        seen.frame_length = m_tdata[ODATA_W-1:2*BYTE_W];
        if (expected_results.size() == 0) begin
          report("result with nothing expected, kind", LEN_W'(seen.kind), '0);
        end else begin
          want = expected_results.pop_front();
          if (seen.kind != want.kind)
            report("kind", LEN_W'(seen.kind), LEN_W'(want.kind));
          if (seen.frame_kind != want.frame_kind)
            report("frame_kind", LEN_W'(seen.frame_kind), LEN_W'(want.frame_kind));
          if (seen.payload_byte != want.payload_byte)
            report("payload_byte", LEN_W'(seen.payload_byte), LEN_W'(want.payload_byte));
          if (seen.last != want.last)
            report("last", LEN_W'(seen.last), LEN_W'(want.last));
          if (seen.frame_length != want.frame_length)
            report("frame_length", seen.frame_length, want.frame_length);
        end
      end
      if (s_tvalid && s_tready) begin
        if (deframe_step(s_tuser, s_tdata, pred))
          expected_results.push_back(pred);
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: dv/tb_start_type_length_frame_receiver.sv
// ---------------------------------------------------------------------------
// tb_start_type_length_frame_receiver
// Feeds received bytes and timeouts into the frame receiver: a handful of
// hand-picked frames first, then random well-formed, rejected and aborted
// frames under several register settings, with random gaps on the input
// and random back-pressure on the output. A checker beside the block
// predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_start_type_length_frame_receiver;
  import stlf_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [BYTE_W-1:0]  s_tdata;    // rx_byte
  logic               s_tuser;    // command
  logic               m_tvalid;
  logic               m_tready;
  logic [ODATA_W-1:0] m_tdata;    // frame_kind, payload_byte, frame_length
  logic [KIND_W-1:0]  m_tuser;    // kind
  logic               m_tlast;    // last
  logic               cfg_we;
  logic               cfg_addr;
  logic [LEN_W-1:0]   cfg_wdata;

  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  int                 frame_items;
  logic [BYTE_W-1:0]  cur_start;
  logic [LEN_W-1:0]   cur_max;
  bit                 tx_calm;
  bit                 rx_calm;
  bit                 timed_out;

  start_type_length_frame_receiver u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  stlf_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random back-pressure on the result side, with calm stretches.
  initial begin
    int stall;
    m_tready = 1'b0;
    rx_calm  = 1'b0;
    stall    = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (stall > 0) begin
        m_tready = 1'b0;
        stall--;
      end else begin
        m_tready = 1'b1;
        if (!rx_calm && $urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  // Entered and left at a falling edge; valid stays high between back-to-back transfers.
  task automatic send(input logic cmd, input logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drain all expected results, then allow for a transfer still in flight.
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_START_BYTE) cur_start = v[BYTE_W-1:0];
    else cur_max = v;
  endtask

  // One frame: optional noise while hunting, then start, type, length and payload.
  // Lengths are mostly small; some are zero or too long, some frames are cut by a timeout.
  task automatic send_frame();
    int               r;
    int               hi;
    int               n;
    int               cut;
    int               i;
    bit               ok;
    logic [LEN_W-1:0] len;
    logic [BYTE_W-1:0] junk;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        junk = BYTE_W'($urandom);
        if (junk == cur_start) junk = junk ^ 8'h01;
        if ($urandom_range(0, 2) == 0) send(CMD_TIMEOUT, junk);
        else send(CMD_BYTE, junk);
      end
    end
    send(CMD_BYTE, cur_start);
    frame_items++;
    r  = $urandom_range(0, 99);
    ok = (cur_max != '0) && (r >= 15);
    if (ok) begin
      hi = (r < 92) ? 16 : 300;
      if (hi > int'(cur_max)) hi = int'(cur_max);
      len = LEN_W'($urandom_range(1, hi));
    end else if (cur_max == 16'hFFFF || r < 6) begin
      len = '0;
    end else begin
      len = LEN_W'($urandom_range(int'(cur_max) + 1, 65535));
    end
    n   = ok ? 3 + int'(len) : 3;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
    for (i = 0; i < n; i++) begin
      frame_items++;
      if (i == cut) begin
        send(CMD_TIMEOUT, BYTE_W'($urandom));
        break;
      end
      case (i)
        0:       send(CMD_BYTE, BYTE_W'($urandom));
        1:       send(CMD_BYTE, len[BYTE_W-1:0]);
        2:       send(CMD_BYTE, len[LEN_W-1:BYTE_W]);
        default: send(CMD_BYTE, BYTE_W'($urandom));
      endcase
    end
  endtask

  task automatic run_random(input int budget);
    frame_items = 0;
    while (frame_items < budget) send_frame();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_BYTE;
    cfg_we    = 1'b0;
    cfg_addr  = REG_START_BYTE;
    cfg_wdata = '0;
    cur_start = START_BYTE_RST;
    cur_max   = MAX_LENGTH_RST;
    tx_calm   = 1'b0;
    timed_out = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    fork
      begin
        // timeout while hunting: dropped
        send(CMD_TIMEOUT, 8'hFF);
        // zero length, then one above the limit
        send(CMD_BYTE, cur_start); send(CMD_BYTE, 8'hFF);
        send(CMD_BYTE, 8'h00);     send(CMD_BYTE, 8'h00);
        send(CMD_BYTE, cur_start); send(CMD_BYTE, 8'h00);
        send(CMD_BYTE, 8'h40);     send(CMD_BYTE, 8'h00);
        // start value carried as type and as payload
        send(CMD_BYTE, cur_start); send(CMD_BYTE, cur_start);
        send(CMD_BYTE, 8'h02);     send(CMD_BYTE, 8'h00);
        send(CMD_BYTE, 8'hFF);     send(CMD_BYTE, cur_start);
        // aborts right after start, after the low length byte, and mid-payload
        send(CMD_BYTE, cur_start); send(CMD_TIMEOUT, 8'h00);
        send(CMD_BYTE, cur_start); send(CMD_BYTE, 8'h12);
        send(CMD_BYTE, 8'h05);     send(CMD_TIMEOUT, 8'h00);
        send(CMD_BYTE, cur_start); send(CMD_BYTE, 8'h34);
        send(CMD_BYTE, 8'h02);     send(CMD_BYTE, 8'h00);
        send(CMD_BYTE, 8'h7E);     send(CMD_TIMEOUT, 8'hFF);
        run_random(400);

        settle();
        write_reg(REG_START_BYTE, 16'h0000);
        write_reg(REG_MAX_LENGTH, 16'd1);
        run_random(300);

        settle();
        write_reg(REG_START_BYTE, 16'h00FF);
        write_reg(REG_MAX_LENGTH, 16'hFFFF);
        // open the longest frame and cut it short
        send(CMD_BYTE, cur_start); send(CMD_BYTE, 8'h3C);
        send(CMD_BYTE, 8'hFF);     send(CMD_BYTE, 8'hFF);
        send(CMD_BYTE, 8'h11);     send(CMD_BYTE, 8'h22);
        send(CMD_TIMEOUT, 8'h00);
        run_random(350);

        // every length rejected
        settle();
        write_reg(REG_MAX_LENGTH, 16'h0000);
        write_reg(REG_START_BYTE, 16'($urandom_range(0, 255)));
        run_random(200);

        settle();
        write_reg(REG_START_BYTE, 16'($urandom_range(0, 255)));
        write_reg(REG_MAX_LENGTH, 16'($urandom_range(2, 40)));
        run_random(500);
        settle();
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/stlf_pkg.sv
rtl/stlf_core.sv
rtl/stlf_out_stage.sv
rtl/start_type_length_frame_receiver.sv
dv/stlf_result_checker.sv
dv/tb_start_type_length_frame_receiver.sv
